@@ design/assert_macros.svh @@
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its trigger
`define ITAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the cycle after its trigger
`define ITAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/itad_pkg.sv @@
// shared types, constants and the digit encoder for the ascii digit converter
`default_nettype none
package itad_pkg;

  localparam int ValueW = 32;
  localparam int MaxW   = 64;
  localparam int CharW  = 7;
  localparam int QDepth = 2;

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharUpper = 7'h41;
  localparam logic [CharW-1:0] CharLower = 7'h61;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              kind;
    logic              upper_case;
    logic              signed_mode;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } out_t;

  // per request mode carried with the magnitude through the queue
  typedef struct packed {
    logic dec;
    logic upper;
  } mode_t;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CharW-1:0] base;
    base = upper ? CharUpper : CharLower;
    if (d < 4'd10) begin
      digit_char = CharZero + CharW'(d);
    end else begin
      digit_char = base + CharW'(d - 4'd10);
    end
  endfunction

endpackage
`default_nettype wire

@@ design/itad_front.sv @@
// front end: takes requests, masks to width and forms the magnitude (negated for negative signed decimal values)
`default_nettype none
module itad_front #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  in_valid_i,
  input  wire itad_pkg::in_t         in_req_i,
  input  wire logic                  q_full_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output logic [DATA_WIDTH-1:0]      mag_o,
  output itad_pkg::mode_t            mode_o
);
  import itad_pkg::*;

  logic [MaxW-1:0]       wide;
  logic [DATA_WIDTH-1:0] v;
  logic                  neg;

  assign wide = {{(MaxW-ValueW){1'b0}}, in_req_i.value};
  assign v    = wide[DATA_WIDTH-1:0];
  assign neg  = in_req_i.kind && in_req_i.signed_mode && v[DATA_WIDTH-1];

  assign mag_o        = neg ? (~v + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : v;
  assign mode_o.dec   = in_req_i.kind;
  assign mode_o.upper = in_req_i.upper_case;
  assign in_stall_o   = q_full_i;
  assign push_o       = in_valid_i && !q_full_i;

endmodule
`default_nettype wire

@@ design/itad_queue.sv @@
// two-entry queue between the front end and the digit engine
`default_nettype none
`include "assert_macros.svh"
module itad_queue #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [DATA_WIDTH-1:0] mag_i,
  input  wire itad_pkg::mode_t       mode_i,
  input  wire logic                  pop_i,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [DATA_WIDTH-1:0]      mag_o,
  output itad_pkg::mode_t            mode_o
);
  import itad_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  logic [DATA_WIDTH-1:0] mag_q  [QDepth];
  mode_t                 mode_q [QDepth];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign mag_o   = mag_q[rd_q];
  assign mode_o  = mode_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mag_q[wr_q]  <= mag_i;
      mode_q[wr_q] <= mode_i;
    end
  end

  `ITAD_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into a full queue")
  `ITAD_ASSERT_NOW(a_no_underflow, pop_i, !empty_o, "pop from an empty queue")

endmodule
`default_nettype wire

@@ design/itad_back.sv @@
// digit engine: shift-and-add-3 decimal conversion or direct hex digit load, leading zero skip, output register
`default_nettype none
`include "assert_macros.svh"
module itad_back #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_empty_i,
  input  wire logic [DATA_WIDTH-1:0] mag_i,
  input  wire itad_pkg::mode_t       mode_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output itad_pkg::out_t             out_req_o
);
  import itad_pkg::*;

  localparam int NumDigits = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int IdxW      = $clog2(NumDigits);
  localparam int CntW      = $clog2(DATA_WIDTH + 1);
  localparam int ExtW      = 4 * NumDigits;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSkip,
    StEmit
  } state_e;

  state_e                state_q;
  logic [3:0]            dig_q [NumDigits];
  logic [3:0]            adj   [NumDigits];
  logic [3:0]            dab   [NumDigits];
  logic [3:0]            hex   [NumDigits];
  logic [DATA_WIDTH-1:0] shr_q;
  logic [CntW-1:0]       cnt_q;
  logic [IdxW-1:0]       idx_q;
  logic                  upper_q;
  logic                  out_valid_q;
  out_t                  out_q;
  logic [ExtW-1:0]       hex_ext;
  logic [3:0]            cur;
  logic                  out_free;

  assign hex_ext  = {{(ExtW-DATA_WIDTH){1'b0}}, mag_i};
  assign cur      = dig_q[idx_q];
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == StIdle) && !q_empty_i;

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // add 3 to digits of five and over, then shift one bit in
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
      hex[i] = hex_ext[4*i +: 4];
    end
    dab[0] = {adj[0][2:0], shr_q[DATA_WIDTH-1]};
    for (int i = 1; i < NumDigits; i++) begin
      dab[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StEmit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (!q_empty_i) begin
            upper_q <= mode_i.upper;
            idx_q   <= IdxW'(NumDigits - 1);
            if (mode_i.dec) begin
              for (int i = 0; i < NumDigits; i++) begin
                dig_q[i] <= '0;
              end
              shr_q   <= mag_i;
              cnt_q   <= CntW'(DATA_WIDTH);
              state_q <= StConv;
            end else begin
              dig_q   <= hex;
              state_q <= StSkip;
            end
          end
        end
        StConv: begin
          dig_q <= dab;
          shr_q <= {shr_q[DATA_WIDTH-2:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_q <= StSkip;
          end
        end
        StSkip: begin
          if (cur == 4'd0 && idx_q != '0) begin
            idx_q <= idx_q - 1'b1;
          end else begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.character <= digit_char(cur, upper_q);
            out_q.last      <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= StIdle;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  `ITAD_ASSERT_NOW(a_conv_count, state_q == StConv, cnt_q != '0,
    "shift counter empty while converting")
  `ITAD_ASSERT_NEXT(a_emit_hold, state_q == StEmit && out_valid_q && out_stall_i,
    $stable(idx_q) && state_q == StEmit, "digit pointer moved under stall")

endmodule
`default_nettype wire

@@ design/integer_to_ascii_digits.sv @@
// top level of the integer to ascii digit converter
//
// Each request carries a value, a radix (hex or decimal), a letter case and
// a signed flag; the block returns the ascii digits most significant first,
// without leading zeros, with last set on the final digit. A two-entry queue
// lets a new request be taken while the previous one is still converting.
// Per request the digit engine loads the value, runs the shift-and-add-3
// steps in decimal (none in hex), skips the leading zero digits, settles
// on the first digit and then emits the digits in turn; the digit array
// holds ten positions at DATA_WIDTH = 32, so without output stalls the time
// a request takes does not depend on its value, and each output stall adds to it.
`default_nettype none
module integer_to_ascii_digits #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire itad_pkg::in_t  in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output itad_pkg::out_t      out_req_o
);
  import itad_pkg::*;

  logic                  push, pop, q_full, q_empty;
  logic [DATA_WIDTH-1:0] f_mag, q_mag;
  mode_t                 f_mode, q_mode;

  itad_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .mag_o      (f_mag),
    .mode_o     (f_mode)
  );

  itad_queue #(.DATA_WIDTH(DATA_WIDTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .mag_i   (f_mag),
    .mode_i  (f_mode),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .mag_o   (q_mag),
    .mode_o  (q_mode)
  );

  itad_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .mag_i       (q_mag),
    .mode_i      (q_mode),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/integer_to_ascii_digits_checker.sv @@
// digit checker: predicts the ascii digits of each accepted request and compares the output stream
module integer_to_ascii_digits_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  itad_pkg::in_t  in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  itad_pkg::out_t out_req_i,
  output int             error_count_o,
  output int             pending_o,
  output int             digits_checked_o
);

  itad_pkg::out_t expected_digits[$];
  int             mismatches = 0;
  int             digits_seen = 0;

  // queue up the digit stream one request should produce
  function automatic void expand_digits(input itad_pkg::in_t r);
    logic [itad_pkg::ValueW-1:0] mag;
    logic [3:0]                  digs [20];
    logic                        is_dec;
    logic [3:0]                  d;
    itad_pkg::out_t              o;
    int                          n;
    mag    = r.value;
    is_dec = r.kind;
    n      = 0;
    // negative two's complement in signed decimal converts as its magnitude
    if (is_dec && r.signed_mode && mag[itad_pkg::ValueW-1]) begin
      mag = ~mag + 1'b1;
    end
    do begin
      if (is_dec) begin
        digs[n] = 4'(mag % 10);
        mag     = mag / 10;
      end else begin
        digs[n] = mag[3:0];
        mag     = mag >> 4;
      end
      n++;
    end while (mag != 0);
    for (int k = 0; k < n; k++) begin
      d = digs[n-1-k];
      if (d < 4'd10) begin
        o.character = itad_pkg::CharZero + 7'(d);
      end else begin
        o.character = (r.upper_case ? itad_pkg::CharUpper : itad_pkg::CharLower) + 7'(d - 4'd10);
      end
      o.last = (k == n - 1);
      expected_digits.push_back(o);
    end
  endfunction

  always @(posedge clk_i) begin
    itad_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        expand_digits(in_req_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_digits.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected digit: expected none actual char %h last %b",
                   $time, out_req_i.character, out_req_i.last);
        end else begin
          want = expected_digits.pop_front();
          digits_seen++;
          if (out_req_i.character !== want.character) begin
            mismatches++;
            $display("%0t: character mismatch: expected %h actual %h",
                     $time, want.character, out_req_i.character);
          end
          if (out_req_i.last !== want.last) begin
            mismatches++;
            $display("%0t: last flag mismatch: expected %b actual %b",
                     $time, want.last, out_req_i.last);
          end
        end
      end
    end
    error_count_o    <= mismatches;
    pending_o        <= expected_digits.size();
    digits_checked_o <= digits_seen;
  end

endmodule

@@ tb/sv/integer_to_ascii_digits_tb.sv @@
// testbench top: drives requests and output stalls into the digit converter and reports the verdict
module integer_to_ascii_digits_tb;

  localparam logic KindHex       = 1'b0;
  localparam logic KindDec       = 1'b1;
  localparam int   RandomItems   = 257;
  localparam int   WatchdogLimit = 2000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  itad_pkg::in_t  in_req = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  itad_pkg::out_t out_req;

  logic           calm_phase = 1'b0;
  logic           drain_outputs = 1'b0;
  int             errors;
  int             pending;
  int             digits_checked;
  int             hex_sent = 0;
  int             dec_sent = 0;
  int             idle_cycles = 0;
  int             stall_hold = 0;
  logic           stall_state = 1'b0;

  always #2 clk_i = ~clk_i;

  integer_to_ascii_digits dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  integer_to_ascii_digits_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_req_i        (out_req),
    .error_count_o    (errors),
    .pending_o        (pending),
    .digits_checked_o (digits_checked)
  );

  // mostly short gaps, a few long ones
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic itad_pkg::in_t make_req(input logic [31:0] v, input logic k,
                                             input logic up, input logic sg);
    itad_pkg::in_t r;
    r.value       = v;
    r.kind        = k;
    r.upper_case  = up;
    r.signed_mode = sg;
    return r;
  endfunction

  // spread of magnitudes so that every digit count turns up
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 20);
      3: return -$urandom_range(1, 20);
      4: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  task automatic send_value(input itad_pkg::in_t r);
    int gap;
    gap = calm_phase ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (r.kind == KindDec) dec_sent++;
    else hex_sent++;
  endtask

  // output stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni || drain_outputs) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_state = !calm_phase && ($urandom_range(0, 99) < 35);
        stall_hold  = gap_length();
      end else begin
        stall_hold--;
      end
      out_stall <= stall_state;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero in hex, unsigned decimal and signed decimal
    send_value(make_req(32'h0000_0000, KindHex, 1'b0, 1'b0));
    send_value(make_req(32'h0000_0000, KindDec, 1'b0, 1'b0));
    send_value(make_req(32'h0000_0000, KindDec, 1'b1, 1'b1));
    // all ones
    send_value(make_req(32'hFFFF_FFFF, KindHex, 1'b1, 1'b0));
    send_value(make_req(32'hFFFF_FFFF, KindHex, 1'b0, 1'b1));
    send_value(make_req(32'hFFFF_FFFF, KindDec, 1'b0, 1'b0));
    send_value(make_req(32'hFFFF_FFFF, KindDec, 1'b1, 1'b1));
    // most negative and most positive signed values
    send_value(make_req(32'h8000_0000, KindDec, 1'b0, 1'b1));
    send_value(make_req(32'h8000_0000, KindDec, 1'b0, 1'b0));
    send_value(make_req(32'h8000_0000, KindHex, 1'b1, 1'b1));
    send_value(make_req(32'h7FFF_FFFF, KindDec, 1'b0, 1'b1));
    send_value(make_req(32'h7FFF_FFFF, KindHex, 1'b1, 1'b0));
    // letter case
    send_value(make_req(32'hABCD_EF12, KindHex, 1'b1, 1'b0));
    send_value(make_req(32'hABCD_EF12, KindHex, 1'b0, 1'b0));
    // digit count boundaries
    send_value(make_req(32'd1000000000, KindDec, 1'b0, 1'b0));
    send_value(make_req(32'd999999999, KindDec, 1'b1, 1'b0));
    send_value(make_req(32'h1000_0000, KindHex, 1'b0, 1'b0));
    send_value(make_req(32'h0FFF_FFFF, KindHex, 1'b1, 1'b0));
    send_value(make_req(32'd9, KindDec, 1'b0, 1'b1));
    send_value(make_req(32'd10, KindDec, 1'b0, 1'b0));
    send_value(make_req(32'd15, KindHex, 1'b0, 1'b0));
    send_value(make_req(32'd15, KindHex, 1'b1, 1'b0));
    send_value(make_req(32'd1, KindHex, 1'b0, 1'b0));

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 35 == 0) calm_phase <= ($urandom_range(0, 3) == 0);
      send_value(make_req(random_value(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
    in_valid      <= 1'b0;
    drain_outputs <= 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Converted %0d requests (%0d hex, %0d decimal) with random gaps and stalls",
             hex_sent + dec_sent, hex_sent, dec_sent);
    $display("Checked %0d digits, %0d mismatches, %0d digits outstanding",
             digits_checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
